/* hw/rtl/rfpl_pkg.sv */
// Shared constants, operation codes and control types of the resonant ladder lowpass.
package rfpl_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Coefficient constants, unsigned Q0.32 (1.16 is Q1.32).
    localparam logic [MUL_W-1:0] K_116   = 33'd4982162063;
    localparam logic [MUL_W-1:0] K_015   = 33'd644245094;
    localparam logic [MUL_W-1:0] K_035   = 33'd1503796899;
    localparam logic [MUL_W-1:0] K_03    = 33'd1288490189;
    localparam logic [MUL_W-1:0] ONE_Q32 = 33'h1_0000_0000;

    localparam logic [MUL_W-1:0] RND_16 = 33'h0_0000_8000;
    localparam logic [MUL_W-1:0] RND_30 = 33'h0_2000_0000;
    localparam logic [MUL_W-1:0] RND_32 = 33'h0_8000_0000;

    localparam int CUTOFF_W   = 15;
    localparam int RES_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = 2'd1;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 15'd6554;
    localparam logic [RES_W-1:0]    RES_RST    = 16'd16384;

    // Operations of the sequencer, in execution order.
    typedef enum logic [3:0] {
        OP_F   = 4'd0,
        OP_F2  = 4'd1,
        OP_F4  = 4'd2,
        OP_G   = 4'd3,
        OP_U   = 4'd4,
        OP_FB  = 4'd5,
        OP_FBS = 4'd6,
        OP_GX  = 4'd7,
        OP_S1P = 4'd8,
        OP_S1O = 4'd9,
        OP_S2P = 4'd10,
        OP_S2O = 4'd11,
        OP_S3P = 4'd12,
        OP_S3O = 4'd13,
        OP_S4P = 4'd14,
        OP_S4O = 4'd15
    } op_t;

    typedef struct packed {
        logic load;
        logic accum;
    } mac_ctrl_t;

endpackage

/* hw/rtl/rfpl_if.sv */
// Handshake channel interfaces for samples and configuration writes.
interface rfpl_in_if #(parameter int W = 16) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface rfpl_out_if #(parameter int W = 16) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface rfpl_cfg_if #(parameter int IW = 2, parameter int DW = 16) ();
    logic          valid;
    logic          ready;
    logic [IW-1:0] index;
    logic [DW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/resonant_four_pole_lowpass.sv */
// Four-pole resonant ladder lowpass built around one shared multiplier.
//
// Usage: audio samples enter on the feed channel, one filtered sample per
// input leaves on the result channel, and the cfg channel writes the cutoff
// (index 0) and resonance (index 1) registers. Configuration is taken at any
// time but should only be written while no sample is in flight.
// Each accepted sample runs sixteen multiply operations through the single
// multiplier: six derive the coefficients from the registers, ten apply the
// feedback, the input gain and the four one-pole stages. An operation passes
// through a multiply state and a retire state, plus an upper multiply state
// for state values when STATE_BITS exceeds 32.
// A new sample is accepted only once the previous one has been handed to
// the result register.
// feed.ready is high only while the sequencer is idle. When the result
// register still holds an unread transaction, the finished sample waits in
// the sequencer until result.ready frees the register.
// Reset clears the stage state to zero and loads cutoff 6554 and resonance
// 16384. Both ready outputs stay low during reset, and the block is ready
// as soon as reset is released.
module resonant_four_pole_lowpass
    import rfpl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int STATE_BITS  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    rfpl_cfg_if.sink    cfg,
    rfpl_in_if.sink     feed,
    rfpl_out_if.source  result
);

    localparam int FRAC  = STATE_BITS - 6;
    localparam int SFRAC = SAMPLE_BITS - 1;
    localparam int UP    = (FRAC >= SFRAC) ? FRAC - SFRAC : 0;
    localparam int DN    = (FRAC >= SFRAC) ? 0 : SFRAC - FRAC;
    localparam int CW    = SAMPLE_BITS + STATE_BITS + 2;
    localparam int PW    = (STATE_BITS + 33 > PROD_W) ? STATE_BITS + 33 : PROD_W;
    localparam int MW    = (STATE_BITS > 32) ? STATE_BITS : MUL_W;
    localparam bit TWO_PASS = (STATE_BITS > 32);

    localparam logic signed [CW-1:0] ST_HI =
        {{(CW - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [CW-1:0] ST_LO = ~ST_HI;
    localparam logic signed [CW-1:0] SM_HI =
        {{(CW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [CW-1:0] SM_LO = ~SM_HI;

    typedef logic signed [STATE_BITS-1:0]  st_t;
    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef logic signed [CW-1:0]          wide_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_UPPER = 5'b00100,
        ST_RET   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Divide by 2^k, rounding to nearest with ties away from zero.
    function automatic wide_t rshr(input wide_t v, input int k);
        logic [CW-1:0] mag;
        logic [CW-1:0] half;
        mag  = v[CW-1] ? -v : v;
        half = (CW'(1) << k) >> 1;
        mag  = (mag + half) >> k;
        return v[CW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic st_t sat_st(input wide_t v);
        if (v > ST_HI)
        begin
            return ST_HI[STATE_BITS-1:0];
        end
        if (v < ST_LO)
        begin
            return ST_LO[STATE_BITS-1:0];
        end
        return v[STATE_BITS-1:0];
    endfunction

    function automatic smp_t sat_sm(input wide_t v);
        if (v > SM_HI)
        begin
            return SM_HI[SAMPLE_BITS-1:0];
        end
        if (v < SM_LO)
        begin
            return SM_LO[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic wide_t sx_st(input st_t v);
        return {{(CW - STATE_BITS){v[STATE_BITS-1]}}, v};
    endfunction

    function automatic wide_t sx_sm(input smp_t v);
        return {{(CW - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    // Control and architectural state.
    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic                rv_reg, rv_next;
    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [RES_W-1:0]    resonance_reg;
    st_t                 out_reg [4];
    st_t                 out_next [4];
    st_t                 prev_reg [4];
    st_t                 prev_next [4];

    // Datapath registers.
    logic [31:0]      f_reg, f_next;
    logic [31:0]      f2_reg, f2_next;
    logic [31:0]      f4_reg, f4_next;
    logic [31:0]      g_reg, g_next;
    logic [31:0]      fb_reg, fb_next;
    logic [MUL_W-1:0] t_reg, t_next;
    logic [MUL_W-1:0] omf_reg, omf_next;
    st_t              s_reg, s_next;
    st_t              x_reg, x_next;
    wide_t            acc_reg, acc_next;
    logic             neg_reg, neg_next;
    smp_t             y_reg, y_next;

    logic             take;
    logic             out_load;
    logic             signed_op;
    logic             sh30;
    logic [1:0]       stg;
    st_t              src;
    logic [STATE_BITS-1:0] mag;
    logic [MW-1:0]    mag_ext;
    logic [MUL_W-1:0] coef;
    logic [MUL_W-1:0] mac_a;
    logic [MUL_W-1:0] mac_b;
    logic [MUL_W-1:0] mac_add;
    mac_ctrl_t        mac_ctrl;
    logic [PW-1:0]    p;
    logic [CW-1:0]    r_mag;
    wide_t            r_s;
    st_t              stage_o;
    smp_t             y_comb;

    assign take      = feed.valid && feed.ready;
    assign feed.ready = rst_n && (state_reg == ST_IDLE);
    assign cfg.ready = rst_n;
    assign result.valid      = rv_reg;
    assign result.sample_out = y_reg;

    assign signed_op = (op_reg >= OP_FBS);
    assign sh30      = (op_reg == OP_FBS);
    assign stg       = op_reg[2:1];

    // Signed operand and coefficient for the state products.
    always_comb
    begin
        case (op_reg)
            OP_FBS:
            begin
                src  = out_reg[3];
                coef = {1'b0, fb_reg};
            end
            OP_GX:
            begin
                src  = x_reg;
                coef = {1'b0, g_reg};
            end
            default:
            begin
                src  = op_reg[0] ? out_reg[stg] : prev_reg[stg];
                coef = op_reg[0] ? omf_reg : K_03;
            end
        endcase
    end

    assign mag     = src[STATE_BITS-1] ? -src : src;
    assign mag_ext = MW'(mag);

    always_comb
    begin
        case (op_reg)
            OP_F:
            begin
                mac_a   = MUL_W'(cutoff_reg);
                mac_b   = K_116;
                mac_add = RND_16;
            end
            OP_F2:
            begin
                mac_a   = {1'b0, f_reg};
                mac_b   = {1'b0, f_reg};
                mac_add = RND_32;
            end
            OP_F4:
            begin
                mac_a   = {1'b0, f2_reg};
                mac_b   = {1'b0, f2_reg};
                mac_add = RND_32;
            end
            OP_G:
            begin
                mac_a   = {1'b0, f4_reg};
                mac_b   = K_035;
                mac_add = RND_32;
            end
            OP_U:
            begin
                mac_a   = {1'b0, f2_reg};
                mac_b   = K_015;
                mac_add = RND_32;
            end
            OP_FB:
            begin
                mac_a   = MUL_W'(resonance_reg);
                mac_b   = t_reg;
                mac_add = RND_16;
            end
            default:
            begin
                mac_a   = (state_reg == ST_UPPER) ? MUL_W'(mag_ext >> 32)
                                                  : {1'b0, mag_ext[31:0]};
                mac_b   = coef;
                mac_add = sh30 ? RND_30 : RND_32;
            end
        endcase
    end

    assign mac_ctrl.load  = (state_reg == ST_MUL);
    assign mac_ctrl.accum = (state_reg == ST_UPPER);

    rfpl_mac #(
        .PW (PW)
    ) u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .a      (mac_a),
        .b      (mac_b),
        .addend (mac_add),
        .p      (p)
    );

    // Rounded magnitude of the last product, then its sign restored.
    assign r_mag   = sh30 ? CW'(p >> 30) : CW'(p >> 32);
    assign r_s     = neg_reg ? -$signed(r_mag) : $signed(r_mag);
    assign stage_o = sat_st(acc_reg + r_s);
    assign y_comb  = sat_sm(rshr(sx_st(x_reg), UP) <<< DN);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (feed.valid)
                begin
                    state_next = ST_MUL;
                    op_next    = OP_F;
                end
            end
            ST_MUL:
            begin
                state_next = (TWO_PASS && signed_op) ? ST_UPPER : ST_RET;
            end
            ST_UPPER:
            begin
                state_next = ST_RET;
            end
            ST_RET:
            begin
                if (op_reg == OP_S4O)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    op_next    = op_t'(op_reg + 4'd1);
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (!rv_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rv_next = rv_reg;
        if (result.valid && result.ready)
        begin
            rv_next = 1'b0;
        end
        if (out_load)
        begin
            rv_next = 1'b1;
        end
    end

    // Datapath updates at accept, multiply, output load and retire.
    always_comb
    begin
        f_next    = f_reg;
        f2_next   = f2_reg;
        f4_next   = f4_reg;
        g_next    = g_reg;
        fb_next   = fb_reg;
        t_next    = t_reg;
        omf_next  = omf_reg;
        s_next    = s_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        y_next    = y_reg;
        out_next  = out_reg;
        prev_next = prev_reg;

        if (take)
        begin
            s_next = sat_st(rshr(sx_sm(feed.sample_in), DN) <<< UP);
        end
        if (state_reg == ST_MUL)
        begin
            neg_next = src[STATE_BITS-1];
        end
        if (out_load)
        begin
            y_next = y_comb;
        end
        if (state_reg == ST_RET)
        begin
            case (op_reg)
                OP_F:
                begin
                    f_next   = p[47:16];
                    omf_next = ONE_Q32 - {1'b0, p[47:16]};
                end
                OP_F2:
                begin
                    f2_next = p[63:32];
                end
                OP_F4:
                begin
                    f4_next = p[63:32];
                end
                OP_G:
                begin
                    g_next = p[63:32];
                end
                OP_U:
                begin
                    t_next = ONE_Q32 - {1'b0, p[63:32]};
                end
                OP_FB:
                begin
                    fb_next = p[47:16];
                end
                OP_FBS:
                begin
                    x_next = sat_st(sx_st(s_reg) - r_s);
                end
                OP_GX:
                begin
                    x_next = sat_st(r_s);
                end
                default:
                begin
                    // Even operations add the previous-input term, odd ones
                    // close the stage with the feedback of its last output.
                    if (!op_reg[0])
                    begin
                        acc_next = sx_st(x_reg) + r_s;
                    end
                    else
                    begin
                        prev_next[stg] = x_reg;
                        out_next[stg]  = stage_o;
                        x_next         = stage_o;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_F;
            rv_reg        <= 1'b0;
            cutoff_reg    <= CUTOFF_RST;
            resonance_reg <= RES_RST;
            out_reg       <= '{default: '0};
            prev_reg      <= '{default: '0};
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            rv_reg    <= rv_next;
            out_reg   <= out_next;
            prev_reg  <= prev_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_CUTOFF:
                    begin
                        cutoff_reg <= cfg.data[CUTOFF_W-1:0];
                    end
                    REG_RESONANCE:
                    begin
                        resonance_reg <= cfg.data[RES_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg   <= f_next;
        f2_reg  <= f2_next;
        f4_reg  <= f4_next;
        g_reg   <= g_next;
        fb_reg  <= fb_next;
        t_reg   <= t_next;
        omf_reg <= omf_next;
        s_reg   <= s_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        y_reg   <= y_next;
    end

`ifndef ASSERT_OFF
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == ST_MUL) && (op_reg == OP_F))
        else $error("sequence did not start at the first operation");

    a_hi_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPPER) |-> (TWO_PASS && (op_reg >= OP_FBS)))
        else $error("upper multiply pass on a coefficient operation");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RET) && (op_reg == OP_S4O)) |=> (state_reg == ST_OUT))
        else $error("last stage retired without moving to output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && result.valid && !result.ready)
            |=> (state_reg == ST_OUT))
        else $error("unread result would be overwritten");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result.valid && (result.sample_out == $past(y_comb)))
        else $error("result register does not hold the finished sample");
`endif

endmodule

/* hw/rtl/rfpl_mac.sv */
// Shared unsigned 33x33 multiplier with a registered product accumulator.
module rfpl_mac
    import rfpl_pkg::*;
#(
    parameter int PW = 66
)
(
    input  logic             clk,
    input  mac_ctrl_t        ctrl,
    input  logic [MUL_W-1:0] a,
    input  logic [MUL_W-1:0] b,
    input  logic [MUL_W-1:0] addend,
    output logic [PW-1:0]    p
);

    logic [PROD_W-1:0] prod;
    logic [PW-1:0]     p_reg;
    logic [PW-1:0]     p_next;

    assign prod = a * b;

    // The upper pass of a wide operand lands 32 bits above the lower one.
    always_comb
    begin
        p_next = p_reg;
        if (ctrl.load)
        begin
            p_next = PW'(prod) + PW'(addend);
        end
        else if (ctrl.accum)
        begin
            p_next = p_reg + (PW'(prod) << 32);
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule
